### rtl/modular_exponentiation_macros.svh
// Assertion helpers shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MODEXP_ASSERT_IMPLIES(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MODEXP_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/modexp_pkg.sv
`default_nettype none

package modexp_pkg;

    // Width of each field on the stream ports
    localparam int FIELD_WIDTH = 64;
    // Default internal operand width
    localparam int OPERAND_WIDTH_DEFAULT = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RED_WAIT,
        ST_BIT,
        ST_MUL_WAIT,
        ST_SQR_WAIT,
        ST_OUT
    } state_t;

    // Operand selection for the shared modular multiplier
    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_MUL,
        OP_SQR
    } mm_op_t;

    typedef struct packed {
        logic   load;
        logic   mm_start;
        mm_op_t mm_op;
        logic   acc_wr;
        logic   sq_wr;
        logic   expo_shift;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic mod_zero;
        logic expo_zero;
        logic expo_lsb;
        logic expo_last;
        logic mm_done;
    } dp_sts_t;

endpackage

`default_nettype wire

### rtl/modexp_mm.sv
`default_nettype none
`include "modular_exponentiation_macros.svh"

// Shift-add-reduce modular multiplier: one multiplier bit per cycle, MSB first.
module modexp_mm #(
    parameter int OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [OPERAND_WIDTH-1:0] mcand,
    input  wire logic [OPERAND_WIDTH-1:0] mplier,
    input  wire logic [OPERAND_WIDTH-1:0] modulus,
    output logic                          done,
    output logic [OPERAND_WIDTH-1:0]      product
);

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     mcand_reg, mcand_next;
    logic [W-1:0]     mplier_reg, mplier_next;
    logic [W-1:0]     mod_reg, mod_next;
    logic [W:0]       mod2_reg, mod2_next;

    logic [W+2:0]     sum;
    logic [W+2:0]     diff1;
    logic [W+2:0]     diff2;
    logic [W-1:0]     step_val;

    // Double the accumulator, add the multiplicand on a one bit, fold below the modulus
    always_comb begin
        sum   = {2'b00, acc_reg, 1'b0}
              + {3'b000, (mplier_reg[W-1] ? mcand_reg : {W{1'b0}})};
        diff1 = sum - {3'b000, mod_reg};
        diff2 = sum - {2'b00, mod2_reg};
        priority if (!diff2[W+2]) begin
            step_val = diff2[W-1:0];
        end else if (!diff1[W+2]) begin
            step_val = diff1[W-1:0];
        end else begin
            step_val = sum[W-1:0];
        end
    end

    // Sequence the bit steps
    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        mod_next    = mod_reg;
        mod2_next   = mod2_reg;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = CNT_W'(W - 1);
            acc_next    = '0;
            mcand_next  = mcand;
            mplier_next = mplier;
            mod_next    = modulus;
            mod2_next   = {modulus, 1'b0};
        end else if (busy_reg) begin
            acc_next    = step_val;
            mplier_next = {mplier_reg[W-2:0], 1'b0};
            cnt_next    = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand and accumulator registers
    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        mod_reg    <= mod_next;
        mod2_reg   <= mod2_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

    `MODEXP_ASSERT_IMPLIES(a_mm_no_restart, aclk, aresetn, start, !busy_reg, "multiplier restarted while busy")
    `MODEXP_ASSERT_NEXT(a_mm_start_busy, aclk, aresetn, start, busy_reg && !done_reg, "multiplier did not start")
    `MODEXP_ASSERT_IMPLIES(a_mm_reduced, aclk, aresetn, done_reg && (mod_reg != '0), acc_reg < mod_reg, "product not reduced")

endmodule

`default_nettype wire

### rtl/modexp_dp.sv
`default_nettype none

// Operand registers, shared multiplier and result register.
module modexp_dp #(
    parameter int OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire modexp_pkg::dp_cmd_t                 cmd,
    output modexp_pkg::dp_sts_t                      sts,
    input  wire logic [3*modexp_pkg::FIELD_WIDTH-1:0] in_data,
    output logic [modexp_pkg::FIELD_WIDTH-1:0]       power_result,
    output logic                                     modulus_error
);

    import modexp_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int XW = (W > FIELD_WIDTH) ? W : FIELD_WIDTH;

    logic [W-1:0]           base_reg;
    logic [W-1:0]           expo_reg;
    logic [W-1:0]           mod_reg;
    logic [W-1:0]           acc_reg;
    logic [W-1:0]           sq_reg;
    logic [FIELD_WIDTH-1:0] result_reg;
    logic                   err_reg;

    logic [XW-1:0]          base_ext;
    logic [XW-1:0]          expo_ext;
    logic [XW-1:0]          mod_ext;
    logic [XW-1:0]          acc_ext;
    logic [W-1:0]           mm_mcand;
    logic [W-1:0]           mm_mplier;
    logic [W-1:0]           mm_product;
    logic                   mm_done;
    logic                   mod_zero;
    logic                   mod_one;

    // Fit the stream fields to the operand width
    assign base_ext = XW'(in_data[FIELD_WIDTH-1:0]);
    assign expo_ext = XW'(in_data[2*FIELD_WIDTH-1:FIELD_WIDTH]);
    assign mod_ext  = XW'(in_data[3*FIELD_WIDTH-1:2*FIELD_WIDTH]);
    assign acc_ext  = XW'(acc_reg);

    assign mod_zero = (mod_reg == '0);
    assign mod_one  = (mod_reg == W'(1));

    // Pick multiplier operands; the unreduced initial one folds to zero for modulus one
    always_comb begin
        unique case (cmd.mm_op)
            OP_REDUCE: begin
                mm_mcand  = W'(1);
                mm_mplier = base_reg;
            end
            OP_MUL: begin
                mm_mcand  = mod_one ? '0 : acc_reg;
                mm_mplier = sq_reg;
            end
            OP_SQR: begin
                mm_mcand  = sq_reg;
                mm_mplier = sq_reg;
            end
            default: begin
                mm_mcand  = '0;
                mm_mplier = '0;
            end
        endcase
    end

    modexp_mm #(
        .OPERAND_WIDTH(W)
    ) u_mm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mm_start),
        .mcand   (mm_mcand),
        .mplier  (mm_mplier),
        .modulus (mod_reg),
        .done    (mm_done),
        .product (mm_product)
    );

    // Operand, accumulator and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            base_reg <= base_ext[W-1:0];
            expo_reg <= expo_ext[W-1:0];
            mod_reg  <= mod_ext[W-1:0];
            acc_reg  <= W'(1);
        end else begin
            if (cmd.acc_wr) begin
                acc_reg <= mm_product;
            end
            if (cmd.expo_shift) begin
                expo_reg <= {1'b0, expo_reg[W-1:1]};
            end
        end
        if (cmd.sq_wr) begin
            sq_reg <= mm_product;
        end
        if (cmd.out_load) begin
            result_reg <= mod_zero ? '0 : acc_ext[FIELD_WIDTH-1:0];
            err_reg    <= mod_zero;
        end
    end

    always_comb begin
        sts.mod_zero  = mod_zero;
        sts.expo_zero = (expo_reg == '0);
        sts.expo_lsb  = expo_reg[0];
        sts.expo_last = (expo_reg[W-1:1] == '0);
        sts.mm_done   = mm_done;
    end

    assign power_result  = result_reg;
    assign modulus_error = err_reg;

endmodule

`default_nettype wire

### rtl/modexp_ctrl.sv
`default_nettype none
`include "modular_exponentiation_macros.svh"

// Sequencer: reduce the base, then multiply and square per exponent bit.
module modexp_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output modexp_pkg::dp_cmd_t      cmd,
    input  wire modexp_pkg::dp_sts_t sts
);

    import modexp_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.mod_zero) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_op    = OP_REDUCE;
                    state_next   = ST_RED_WAIT;
                end
            end
            ST_RED_WAIT: begin
                if (sts.mm_done) begin
                    cmd.sq_wr  = 1'b1;
                    state_next = ST_BIT;
                end
            end
            ST_BIT: begin
                priority if (sts.expo_zero) begin
                    state_next = ST_OUT;
                end else if (sts.expo_lsb) begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_op    = OP_MUL;
                    state_next   = ST_MUL_WAIT;
                end else begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_op    = OP_SQR;
                    state_next   = ST_SQR_WAIT;
                end
            end
            ST_MUL_WAIT: begin
                if (sts.mm_done) begin
                    cmd.acc_wr = 1'b1;
                    // Skip the final squaring: nothing reads it
                    if (sts.expo_last) begin
                        state_next = ST_OUT;
                    end else begin
                        cmd.mm_start = 1'b1;
                        cmd.mm_op    = OP_SQR;
                        state_next   = ST_SQR_WAIT;
                    end
                end
            end
            ST_SQR_WAIT: begin
                if (sts.mm_done) begin
                    cmd.sq_wr      = 1'b1;
                    cmd.expo_shift = 1'b1;
                    state_next     = ST_BIT;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until its transaction completes
    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    `MODEXP_ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, cmd.out_load, !out_valid_reg || m_tready, "result overwritten before transaction")
    `MODEXP_ASSERT_IMPLIES(a_done_in_wait, aclk, aresetn, sts.mm_done, (state_reg == ST_RED_WAIT) || (state_reg == ST_MUL_WAIT) || (state_reg == ST_SQR_WAIT), "multiplier done outside a wait state")

endmodule

`default_nettype wire

### rtl/modular_exponentiation.sv
// Items are handled one at a time; each modular product runs through the shared
// shift-add-reduce multiplier, and each exponent bit needs one or two of them.
// A new item is taken while the previous result still waits on the output register.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops m_tvalid.
`default_nettype none

module modular_exponentiation #(
    parameter int OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH_DEFAULT
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // s_tdata: base_value [63:0], exponent_value [127:64], modulus_value [191:128]
    input  wire logic [3*modexp_pkg::FIELD_WIDTH-1:0] s_tdata,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // m_tdata: power_result [63:0]
    output logic [modexp_pkg::FIELD_WIDTH-1:0]        m_tdata,
    // m_tuser: modulus_error [0]
    output logic                                      m_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready
);

    import modexp_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    modexp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    modexp_dp #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .in_data       (s_tdata),
        .power_result  (m_tdata),
        .modulus_error (m_tuser)
    );

endmodule

`default_nettype wire
